// ===== rtl/bmm_pkg.sv =====
// shared types and constants of the banked memory mapper
`default_nettype none
package bmm_pkg;

  localparam int ADDR_W         = 16;
  localparam int DATA_W         = 8;
  localparam int OFFSET_W       = 22;
  localparam int PAGE_CNT_W     = 9;
  localparam int WIN_LOW_W      = 13;
  localparam int WORK_RAM_BYTES = 8192;
  localparam int MAX_ROM_PAGES  = 256;

  localparam logic [ADDR_W-1:0]     BANK_REG_BASE = 16'hFFFC;
  localparam logic [PAGE_CNT_W-1:0] PAGES_MAX     = PAGE_CNT_W'(MAX_ROM_PAGES);

  typedef enum logic [1:0] {
    MODE_BANKED = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_BIOS   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MACHINE_MODE   = 2'd0,
    CFG_ROM_PAGE_COUNT = 2'd1,
    CFG_SRAM_PRESENT   = 2'd2,
    CFG_BIOS_PRESENT   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    REG_ROM     = 3'd0,
    REG_RAM     = 3'd1,
    REG_SRAM    = 3'd2,
    REG_BIOS    = 3'd3,
    REG_DISCARD = 3'd4
  } region_t;

  typedef enum logic [1:0] {
    SRC_ROM     = 2'd0,
    SRC_SRAM_LO = 2'd1,
    SRC_SRAM_HI = 2'd2,
    SRC_DISCARD = 2'd3
  } src_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/bmm_if.sv =====
// valid/ready channel interfaces for access, result and configuration beats
`default_nettype none
interface bmm_in_if import bmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] cpu_address;
  logic [DATA_W-1:0] write_byte;
  modport source (output valid, operation, cpu_address, write_byte, input ready);
  modport sink   (input valid, operation, cpu_address, write_byte, output ready);
endinterface

interface bmm_out_if import bmm_pkg::*; ();
  logic                valid;
  logic                ready;
  region_t             target_region;
  logic [OFFSET_W-1:0] target_offset;
  logic                is_store;
  modport source (output valid, target_region, target_offset, is_store, input ready);
  modport sink   (input valid, target_region, target_offset, is_store, output ready);
endinterface

interface bmm_cfg_if import bmm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [PAGE_CNT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bmm_mod_unit.sv =====
// bit-serial restoring remainder unit: 8-bit dividend modulo the page count
`default_nettype none
module bmm_mod_unit import bmm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_W-1:0]     dividend,
  input  wire logic [PAGE_CNT_W-1:0] divisor,
  output      logic                  done,
  output      logic [DATA_W-1:0]     remainder
);

  localparam int CNT_W = $clog2(DATA_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DATA_W-1:0]     dvd;
  logic [PAGE_CNT_W-1:0] div;
  logic [DATA_W:0]       shifted;
  logic [DATA_W:0]       diff;

  // remainder stays below divisor, so it fits in a byte
  assign shifted = {remainder, dvd[DATA_W-1]};
  assign diff    = shifted - div;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      div       <= divisor;
    end else if (busy) begin
      dvd <= {dvd[DATA_W-2:0], 1'b0};
      if (shifted >= div) begin
        remainder <= diff[DATA_W-1:0];
      end else begin
        remainder <= shifted[DATA_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/banked_memory_mapper_unit.sv =====
// top level: access sequencer, bank registers and address translation
//
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------
//  in_ch    | in  | operation, cpu_address, write_byte
//  out_ch   | out | target_region, target_offset, is_store
//  cfg      | in  | index, data (machine_mode .. bios_present)
//
// each access runs eight remainder steps, enters the result step on done
// and then translates; a new access is taken only once back in idle.
// rst is synchronous and restores config and bank state to power-on values.
// in_ch.ready is high only while idle; a result waiting on out_ch holds the
// translation step and blocks the next access. cfg is always ready; the user
// must write it only while no access is in flight, which is not enforced.
`default_nettype none
module banked_memory_mapper_unit import bmm_pkg::*; (
  input wire logic   clk,
  input wire logic   rst,
  bmm_in_if.sink     in_ch,
  bmm_out_if.source  out_ch,
  bmm_cfg_if.sink    cfg
);

  state_t state, state_next;

  mode_t                 machine_mode;
  logic [PAGE_CNT_W-1:0] rom_page_count;
  logic                  sram_present;
  logic                  bios_present;

  logic [DATA_W-1:0] bank_regs [4];
  logic [DATA_W-1:0] window_rom_page [3];
  src_t              upper_window_source;

  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;

  logic                  in_acc;
  logic                  out_free;
  logic                  finish;
  logic                  mod_done;
  logic [DATA_W-1:0]     mod_rem;
  logic [DATA_W-1:0]     mod_dvd;
  logic [PAGE_CNT_W-1:0] pages;

  logic [2:0]           win;
  logic [WIN_LOW_W-1:0] low;
  region_t              region;
  logic [OFFSET_W-1:0]  off;
  logic [DATA_W-1:0]    cur_page;
  logic                 bank_wr;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign finish   = (state == S_DONE) && out_free;
  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  // effective page count: zero counts as one, saturate at the maximum
  always_comb begin
    pages = rom_page_count;
    if (rom_page_count == '0) pages = PAGE_CNT_W'(1);
    if (rom_page_count > PAGES_MAX) pages = PAGES_MAX;
  end

  // pick what the remainder unit reduces for this access
  always_comb begin
    if (machine_mode == MODE_BIOS) begin
      mod_dvd = DATA_W'(in_ch.cpu_address[WIN_LOW_W+1:WIN_LOW_W]);
    end else if (in_ch.cpu_address[1:0] == 2'd0) begin
      mod_dvd = bank_regs[3];
    end else begin
      mod_dvd = in_ch.write_byte;
    end
  end

  bmm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (in_acc),
    .dividend  (mod_dvd),
    .divisor   (pages),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc) state_next = S_RUN;
      S_RUN:  if (mod_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op   <= in_ch.operation;
      addr <= in_ch.cpu_address;
      data <= in_ch.write_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_mode   <= MODE_BANKED;
      rom_page_count <= PAGE_CNT_W'(1);
      sram_present   <= 1'b0;
      bios_present   <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MACHINE_MODE:   machine_mode   <= mode_t'(cfg.data[1:0]);
        CFG_ROM_PAGE_COUNT: rom_page_count <= cfg.data;
        CFG_SRAM_PRESENT:   sram_present   <= cfg.data[0];
        CFG_BIOS_PRESENT:   bios_present   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign win      = addr[ADDR_W-1:WIN_LOW_W];
  assign low      = addr[WIN_LOW_W-1:0];
  assign cur_page = (win[2:1] == 2'd0) ? window_rom_page[0] :
                    (win[2:1] == 2'd1) ? window_rom_page[1] : window_rom_page[2];

  // translation, from the bank state as it was before this access
  always_comb begin
    region  = REG_DISCARD;
    off     = OFFSET_W'(low);
    bank_wr = 1'b0;
    case (machine_mode)
      MODE_FIXED: begin
        if (!win[2]) begin
          if (!op) begin
            region = REG_ROM;
            off    = OFFSET_W'({win, low});
          end
        end else if (sram_present) begin
          region = REG_SRAM;
          off    = OFFSET_W'({win[1:0], low});
        end else if (win[1]) begin
          region = REG_RAM;
        end
      end
      MODE_BIOS: begin
        if (win == 3'd0) begin
          if (bios_present && !op) region = REG_BIOS;
        end else if (win == 3'd3) begin
          region = REG_RAM;
        end else if (win[2] && !op) begin
          region = REG_ROM;
          off    = OFFSET_W'({mod_rem[1:0], low});
        end
      end
      default: begin
        if (win[2:1] != 2'b11) begin
          if (!win[2] || upper_window_source == SRC_ROM) begin
            if (!op) begin
              region = REG_ROM;
              off    = {cur_page, win[0], low};
            end
          end else if (upper_window_source != SRC_DISCARD) begin
            region = REG_SRAM;
            off    = OFFSET_W'({upper_window_source == SRC_SRAM_HI, win[0], low});
          end
        end else begin
          region = REG_RAM;
        end
        bank_wr = op && (addr >= BANK_REG_BASE);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_regs[0]        <= '0;
      bank_regs[1]        <= '0;
      bank_regs[2]        <= DATA_W'(1);
      bank_regs[3]        <= '0;
      window_rom_page[0]  <= '0;
      window_rom_page[1]  <= DATA_W'(1);
      window_rom_page[2]  <= '0;
      upper_window_source <= SRC_ROM;
    end else if (finish && bank_wr) begin
      bank_regs[addr[1:0]] <= data;
      case (addr[1:0])
        2'd0: begin
          if (data[3]) begin
            if (sram_present) begin
              upper_window_source <= data[2] ? SRC_SRAM_HI : SRC_SRAM_LO;
            end else begin
              upper_window_source <= SRC_DISCARD;
            end
          end else begin
            window_rom_page[2]  <= mod_rem;
            upper_window_source <= SRC_ROM;
          end
        end
        2'd1: window_rom_page[0] <= mod_rem;
        2'd2: window_rom_page[1] <= mod_rem;
        default: if (!bank_regs[0][3]) window_rom_page[2] <= mod_rem;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (finish) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_ch.target_region <= region;
      out_ch.target_offset <= off;
      out_ch.is_store      <= op;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("access accepted while a previous one is in flight");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == S_RUN)
    else $error("remainder unit finished outside an access");

  a_rem_below_pages: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> PAGE_CNT_W'(mod_rem) < pages)
    else $error("remainder not below the page count");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_ch.valid && !out_ch.ready) |=> state == S_DONE)
    else $error("result step left while the output was still occupied");

endmodule
`default_nettype wire
